FILE: rtl/kps_pkg.sv
package kps_pkg;

    // Command codes
    localparam logic [1:0] CMD_SCAN  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    // Column numbers
    localparam logic [1:0] COL_FIRST = 2'd0;
    localparam logic [1:0] COL_LAST  = 2'd2;
    localparam logic [1:0] COL_BAD   = 2'd3;

    // Active-low column strobes
    localparam logic [2:0] STROBE_COL0 = 3'b110;
    localparam logic [2:0] STROBE_COL1 = 3'b101;
    localparam logic [2:0] STROBE_COL2 = 3'b011;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] row_sense;
    } in_item_t;

    typedef struct packed {
        logic [6:0] key_char;
        logic [2:0] column_drive;
    } out_item_t;

    // One transaction moving from the input stage into the scan core
    typedef struct packed {
        logic     fire;
        in_item_t item;
    } kps_step_t;

    // Row decode of one column sample
    typedef struct packed {
        logic       hit;     // at least one row pressed
        logic       single;  // exactly one row pressed
        logic [6:0] code;    // ASCII of the key when single
    } kps_decode_t;

    // Keypad legend: backspace / 0 / newline on row 0, then 7-9, 4-6, 1-3
    function automatic logic [6:0] key_code(input logic [1:0] col, input logic [1:0] row);
        logic [6:0] code;
        code = 7'd0;
        unique case (row)
            2'd0:
            begin
                unique case (col)
                    2'd1:    code = 7'd48;
                    2'd2:    code = 7'd10;
                    default: code = 7'd8;
                endcase
            end
            2'd1:
            begin
                unique case (col)
                    2'd1:    code = 7'd56;
                    2'd2:    code = 7'd57;
                    default: code = 7'd55;
                endcase
            end
            2'd2:
            begin
                unique case (col)
                    2'd1:    code = 7'd53;
                    2'd2:    code = 7'd54;
                    default: code = 7'd52;
                endcase
            end
            default:
            begin
                unique case (col)
                    2'd1:    code = 7'd50;
                    2'd2:    code = 7'd51;
                    default: code = 7'd49;
                endcase
            end
        endcase
        return code;
    endfunction

    function automatic logic [2:0] column_strobe(input logic [1:0] col);
        logic [2:0] strobe;
        unique case (col)
            2'd1:    strobe = STROBE_COL1;
            2'd2:    strobe = STROBE_COL2;
            default: strobe = STROBE_COL0;
        endcase
        return strobe;
    endfunction

endpackage

FILE: rtl/kps_stream_if.sv
interface kps_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/kps_key_decode.sv
module kps_key_decode (
    input  logic [1:0]          col,
    input  logic [3:0]          row_sense,
    output kps_pkg::kps_decode_t dec
);
    import kps_pkg::*;

    logic [3:0] rows;
    logic [1:0] row;
    logic       single;

    // Lines are active low
    assign rows = ~row_sense;

    // One-hot row detect
    always_comb
    begin
        row    = 2'd0;
        single = 1'b0;
        unique case (rows)
            4'b0001:
            begin
                row    = 2'd0;
                single = 1'b1;
            end
            4'b0010:
            begin
                row    = 2'd1;
                single = 1'b1;
            end
            4'b0100:
            begin
                row    = 2'd2;
                single = 1'b1;
            end
            4'b1000:
            begin
                row    = 2'd3;
                single = 1'b1;
            end
            default:
            begin
                row    = 2'd0;
                single = 1'b0;
            end
        endcase
    end

    assign dec.hit    = (rows != 4'd0);
    assign dec.single = single;
    assign dec.code   = key_code(col, row);

endmodule

FILE: rtl/kps_scan_core.sv
module kps_scan_core (
    input  logic               clk,
    input  logic               rst_n,
    input  kps_pkg::kps_step_t step,
    output kps_pkg::out_item_t result
);
    import kps_pkg::*;

    logic [1:0]  col_reg, col_next;
    logic        scan_invalid_reg, scan_invalid_next;
    logic [6:0]  scan_code_reg, scan_code_next;
    logic        last_released_reg, last_released_next;
    logic [6:0]  key_buf_reg, key_buf_next;

    logic [1:0]  col_cur;
    logic        base_invalid;
    logic [6:0]  base_code;
    kps_decode_t dec;

    // Column index three never arises; treat it as column zero
    assign col_cur = (col_reg == COL_BAD) ? COL_FIRST : col_reg;

    kps_key_decode u_decode (
        .col       (col_cur),
        .row_sense (step.item.row_sense),
        .dec       (dec)
    );

    // Scan result is cleared at the start of each scan
    assign base_invalid = (col_cur == COL_FIRST) ? 1'b0 : scan_invalid_reg;
    assign base_code    = (col_cur == COL_FIRST) ? 7'd0 : scan_code_reg;

    // State update for one transaction
    always_comb
    begin
        col_next           = col_reg;
        scan_invalid_next  = scan_invalid_reg;
        scan_code_next     = scan_code_reg;
        last_released_next = last_released_reg;
        key_buf_next       = key_buf_reg;
        if (step.fire)
        begin
            priority if (step.item.cmd == CMD_SCAN)
            begin
                scan_invalid_next = base_invalid;
                scan_code_next    = base_code;
                if (dec.hit)
                begin
                    if (base_invalid || (base_code != 7'd0) || !dec.single)
                    begin
                        scan_invalid_next = 1'b1;
                        scan_code_next    = 7'd0;
                    end
                    else
                    begin
                        scan_invalid_next = 1'b0;
                        scan_code_next    = dec.code;
                    end
                end
                if (col_cur == COL_LAST)
                begin
                    // End of scan: latch a fresh key after a released scan
                    col_next = COL_FIRST;
                    if (last_released_reg && !scan_invalid_next && (scan_code_next != 7'd0))
                    begin
                        key_buf_next = scan_code_next;
                    end
                    last_released_next = !scan_invalid_next && (scan_code_next == 7'd0);
                end
                else
                begin
                    col_next = col_cur + 2'd1;
                end
            end
            else if (step.item.cmd == CMD_READ || step.item.cmd == CMD_FLUSH)
            begin
                key_buf_next = 7'd0;
            end
            else
            begin
                key_buf_next = key_buf_reg;
            end
        end
    end

    // Result for the transaction being processed
    assign result.key_char     = (step.item.cmd == CMD_READ) ? key_buf_reg : 7'd0;
    assign result.column_drive = column_strobe(col_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg           <= COL_FIRST;
            scan_invalid_reg  <= 1'b1;
            scan_code_reg     <= 7'd0;
            last_released_reg <= 1'b0;
            key_buf_reg       <= 7'd0;
        end
        else
        begin
            col_reg           <= col_next;
            scan_invalid_reg  <= scan_invalid_next;
            scan_code_reg     <= scan_code_next;
            last_released_reg <= last_released_next;
            key_buf_reg       <= key_buf_next;
        end
    end

endmodule

FILE: rtl/keypad_scan_decoder.sv
// Channel   Direction  Payload                        Role
// cmd_ch    sink       cmd[1:0], row_sense[3:0]       scan tick, read or flush
// key_ch    source     key_char[6:0], column_drive[2:0]  one result per command
//
// One transaction per cycle sustained while key_ch is not stalled; key_ch valid rises after cmd_ch
// acceptance, once the item has passed the input register and then the result register.
// State is updated as a transaction leaves the input register for the result register.
// Reset zeroes the column, scan code and key buffer, marks the scan invalid, clears the valids.
// A key_ch stall holds the result register and backs up into the input register;
// cmd_ch ready drops only when both stages are full and key_ch is stalled.
module keypad_scan_decoder (
    input  logic         clk,
    input  logic         rst_n,
    kps_stream_if.sink   cmd_ch,
    kps_stream_if.source key_ch
);
    import kps_pkg::*;

    logic      stage_valid_reg, stage_valid_next;
    in_item_t  stage_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;

    logic      out_free;
    logic      stage_adv;
    logic      in_fire;
    kps_step_t step;
    out_item_t result;

    // Handshake control
    assign out_free     = !out_valid_reg || key_ch.ready;
    assign stage_adv    = stage_valid_reg && out_free;
    assign cmd_ch.ready = !stage_valid_reg || stage_adv;
    assign in_fire      = cmd_ch.valid && cmd_ch.ready;

    assign stage_valid_next = in_fire ? 1'b1 : (stage_adv ? 1'b0 : stage_valid_reg);
    assign out_valid_next   = stage_adv ? 1'b1 : (key_ch.ready ? 1'b0 : out_valid_reg);

    assign step.fire = stage_adv;
    assign step.item = stage_item_reg;

    kps_scan_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .result (result)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_item_reg <= cmd_ch.data;
        end
        if (stage_adv)
        begin
            out_item_reg <= result;
        end
    end

    assign key_ch.valid = out_valid_reg;
    assign key_ch.data  = out_item_reg;

    // Checks
    a_in_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> stage_valid_reg)
        else $error("accepted transaction not held in input stage");

    a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        stage_adv |=> out_valid_reg)
        else $error("advanced transaction not presented on key channel");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !stage_adv) |=> (stage_valid_reg && $stable(stage_item_reg)))
        else $error("stalled input stage lost its transaction");

    a_drive_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.column_drive == STROBE_COL0
                           || out_item_reg.column_drive == STROBE_COL1
                           || out_item_reg.column_drive == STROBE_COL2))
        else $error("illegal column strobe");

endmodule
